### design/cbpf_pkg.sv
// Shared types, constants and the arithmetic micro-program of the Bezier path flattener.
package cbpf_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = 25;
    localparam int TOL_W       = 23;
    localparam int CNT_W       = 16;
    localparam int T_W         = 6;
    localparam int MUL_W       = 27;
    localparam int PROD_W      = 54;
    localparam int SQ_W        = 52;
    localparam int HALF_W      = 26;
    localparam int ACC_W       = 108;
    localparam int STEP_W      = 5;
    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 216;
    localparam int OUT_FIELD_W = 214;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 23'd64;
    localparam logic [STEP_W-1:0] STEP_POINT = 5'd11;
    localparam logic [STEP_W-1:0] STEP_LAST  = 5'd26;
    localparam logic [T_W-1:0]    T_HALF     = 6'd32;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        OP_MOVE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_CURVE = 2'd2,
        OP_CLOSE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_CUBIC = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt;

    typedef struct packed {
        t_pt            p3;
        t_pt            p2;
        t_pt            p1;
        t_pt            p0;
        logic [T_W-1:0] t0;
    } t_seg;

    typedef enum logic [3:0] {
        OPD_ZERO, OPD_TOL, OPD_LX, OPD_LY, OPD_DX, OPD_DY, OPD_EX, OPD_EY,
        OPD_CLO, OPD_CHI, OPD_TLO, OPD_THI, OPD_NLO, OPD_NHI
    } t_opnd;

    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} t_acc_op;

    typedef enum logic [1:0] {SH_0, SH_26, SH_52} t_shift;

    typedef enum logic [3:0] {
        ST_NONE, ST_TOL2, ST_LEN2, ST_DOT, ST_D2, ST_E2, ST_CROSS, ST_C2, ST_RHS
    } t_store;

    typedef struct packed {
        t_opnd   a;
        t_opnd   b;
        t_acc_op acc;
        t_shift  sh;
        t_store  st;
    } t_uop;

    typedef enum logic [2:0] {
        S_IDLE, S_SPAN, S_CHECK, S_MATH, S_DECIDE, S_LEAF
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              emit_line;
        logic              setup;
        logic              pt_sel;
        logic              step_en;
        logic [STEP_W-1:0] step;
        logic              split;
        logic              emit_leaf;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic near;
        logic at_max;
        logic stack_empty;
    } t_dp_sts;

    function automatic t_coord half_floor(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    function automatic t_uop mk(input t_opnd a, input t_opnd b, input t_acc_op acc,
                                input t_shift sh, input t_store st);
        t_uop u;
        u.a   = a;
        u.b   = b;
        u.acc = acc;
        u.sh  = sh;
        u.st  = st;
        return u;
    endfunction

    // One product is issued per step; it is registered, then taken into the accumulator,
    // and a later step stores the sum. The chord part runs once per test, the point part
    // (from STEP_POINT) for the first control point and, if that one is near, the second.
    function automatic t_uop uop_of(input logic [STEP_W-1:0] step);
        t_uop u;
        u = mk(OPD_ZERO, OPD_ZERO, ACC_NONE, SH_0, ST_NONE);
        unique case (step)
            5'd0:  u = mk(OPD_TOL,  OPD_TOL,  ACC_LOAD, SH_0,  ST_NONE);
            5'd1:  u = mk(OPD_LX,   OPD_LX,   ACC_LOAD, SH_0,  ST_NONE);
            5'd2:  u = mk(OPD_LY,   OPD_LY,   ACC_ADD,  SH_0,  ST_TOL2);
            5'd4:  u = mk(OPD_ZERO, OPD_ZERO, ACC_NONE, SH_0,  ST_LEN2);
            5'd5:  u = mk(OPD_TLO,  OPD_NLO,  ACC_LOAD, SH_0,  ST_NONE);
            5'd6:  u = mk(OPD_TLO,  OPD_NHI,  ACC_ADD,  SH_26, ST_NONE);
            5'd7:  u = mk(OPD_THI,  OPD_NLO,  ACC_ADD,  SH_26, ST_NONE);
            5'd8:  u = mk(OPD_THI,  OPD_NHI,  ACC_ADD,  SH_52, ST_NONE);
            5'd10: u = mk(OPD_ZERO, OPD_ZERO, ACC_NONE, SH_0,  ST_RHS);
            5'd11: u = mk(OPD_DX,   OPD_LX,   ACC_LOAD, SH_0,  ST_NONE);
            5'd12: u = mk(OPD_DY,   OPD_LY,   ACC_ADD,  SH_0,  ST_NONE);
            5'd13: u = mk(OPD_DX,   OPD_DX,   ACC_LOAD, SH_0,  ST_NONE);
            5'd14: u = mk(OPD_DY,   OPD_DY,   ACC_ADD,  SH_0,  ST_DOT);
            5'd15: u = mk(OPD_EX,   OPD_EX,   ACC_LOAD, SH_0,  ST_NONE);
            5'd16: u = mk(OPD_EY,   OPD_EY,   ACC_ADD,  SH_0,  ST_D2);
            5'd17: u = mk(OPD_DX,   OPD_LY,   ACC_LOAD, SH_0,  ST_NONE);
            5'd18: u = mk(OPD_DY,   OPD_LX,   ACC_SUB,  SH_0,  ST_E2);
            5'd20: u = mk(OPD_ZERO, OPD_ZERO, ACC_NONE, SH_0,  ST_CROSS);
            5'd21: u = mk(OPD_CLO,  OPD_CLO,  ACC_LOAD, SH_0,  ST_NONE);
            5'd22: u = mk(OPD_CHI,  OPD_CLO,  ACC_ADD,  SH_26, ST_NONE);
            5'd23: u = mk(OPD_CHI,  OPD_CLO,  ACC_ADD,  SH_26, ST_NONE);
            5'd24: u = mk(OPD_CHI,  OPD_CHI,  ACC_ADD,  SH_52, ST_NONE);
            5'd26: u = mk(OPD_ZERO, OPD_ZERO, ACC_NONE, SH_0,  ST_C2);
            default: ;
        endcase
        return u;
    endfunction

endpackage

### design/cubic_bezier_path_flattener_top.sv
// Top level of the cubic Bezier path flattener: controller, datapath and stream ports.
//
// The block reads path commands (move, line, cubic curve, close) one beat at a time and
// writes line, closing-line and cubic-piece spans. It keeps the current point, the
// subpath start and a 16-bit command counter that numbers every command. A curve is
// halved depth first, left half before right, until both control points lie within
// the flatness tolerance of the chord or MAX_DEPTH halvings have been made; each leaf
// becomes one span with its start parameter in 1/64 units and tlast on the final one.
// A move is taken in the idle state; a line or close then passes through a span state.
// For each flatness test of a curve there is a setup step, then the shared 27 x 27
// multiply-accumulate unit works through the chord and the first control point and,
// if that point is near, the second one; then the curve is split, or a leaf is
// decided and emitted. A leaf at the depth limit needs no test. The single multiplier
// forms all squared distances and their 108-bit exact products serially and so sets
// the pace of the block. The output register lets a finished span wait while the
// next command is taken in.
module cubic_bezier_path_flattener_top #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    // Flatness tolerance, same Q15.8 units as the coordinates.
    input  logic [cbpf_pkg::TOL_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y (24 bits each).
    input  logic [cbpf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation.
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // command_number (16), t_start (6), start_x, start_y, end_x, end_y, ctrl1_x,
    // ctrl1_y, ctrl2_x, ctrl2_y (24 each), two zero bits.
    output logic [cbpf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // span_kind.
    output logic [1:0]                         m_axis_tuser,
    // last_of_run.
    output logic                               m_axis_tlast
);
    import cbpf_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cbpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cbpf_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

### design/cbpf_ctrl.sv
// Controller state machine that sequences commands, flatness tests and span output.
module cbpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_op,
    output logic              o_ready,
    input  cbpf_pkg::t_dp_sts i_sts,
    output cbpf_pkg::t_dp_cmd o_cmd
);
    import cbpf_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_pt, n_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pt    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pt    <= n_pt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pt    = r_pt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_MOVE:           n_state = S_IDLE;
                        OP_CURVE:          n_state = S_CHECK;
                        OP_LINE, OP_CLOSE: n_state = S_SPAN;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_SPAN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.at_max) begin
                    n_state = S_LEAF;
                end else begin
                    n_state = S_MATH;
                    n_step  = '0;
                    n_pt    = 1'b0;
                end
            end
            S_MATH: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DECIDE: begin
                if (!i_sts.near) begin
                    n_state = S_CHECK;
                end else if (!r_pt) begin
                    n_state = S_MATH;
                    n_step  = STEP_POINT;
                    n_pt    = 1'b1;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.stack_empty ? S_IDLE : S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_SPAN:  o_cmd.emit_line = i_sts.out_free;
            S_CHECK: o_cmd.setup     = !i_sts.at_max;
            S_MATH: begin
                o_cmd.step_en = 1'b1;
                o_cmd.step    = r_step;
            end
            S_DECIDE: begin
                o_cmd.split  = !i_sts.near;
                o_cmd.setup  = i_sts.near && !r_pt;
                o_cmd.pt_sel = 1'b1;
            end
            S_LEAF:  o_cmd.emit_leaf = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

### design/cbpf_dp.sv
// Datapath: path state, split stack, multiply-accumulate unit, flatness compare and output register.
module cbpf_dp #(
    parameter int MAX_DEPTH = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [cbpf_pkg::TOL_W-1:0]         i_cfg_wdata,
    input  logic [1:0]                         i_op,
    input  logic [cbpf_pkg::IN_DATA_W-1:0]     i_data,
    input  cbpf_pkg::t_dp_cmd                  i_cmd,
    output cbpf_pkg::t_dp_sts                  o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [cbpf_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [1:0]                         o_out_kind,
    output logic                               o_out_last
);
    import cbpf_pkg::*;

    localparam int SP_W    = $clog2(MAX_DEPTH + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int SIDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Configuration and path state.
    logic [TOL_W-1:0] r_tol;
    t_pt              r_cur, r_sub;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_op;
    t_pt              r_in_p1;

    // Segment under test and the pending right halves.
    t_seg               r_seg;
    logic [DEPTH_W-1:0] r_depth;
    logic [SP_W-1:0]    r_sp;
    t_seg               r_stk_seg [MAX_DEPTH];
    logic [DEPTH_W-1:0] r_stk_dep [MAX_DEPTH];

    // Distance test operands and results.
    logic signed [DIFF_W-1:0] r_lx, r_ly, r_dx, r_dy, r_ex, r_ey;
    logic signed [PROD_W-1:0] r_prod;
    t_acc_op                  r_pend_acc;
    t_shift                   r_pend_sh;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SQ_W-1:0]          r_tol2, r_len2, r_d2, r_e2, r_cabs;
    logic signed [SQ_W-1:0]   r_dot;
    logic [ACC_W-1:0]         r_c2, r_rhs;

    // Output register.
    logic                    r_o_valid;
    logic [OUT_DATA_W-1:0]   r_o_data;
    logic [1:0]              r_o_kind;
    logic                    r_o_last;

    t_pt                      w_in_p1, w_in_p2, w_in_p3, w_pt, w_line_end;
    t_seg                     w_left, w_right;
    logic [T_W-1:0]           w_half;
    t_uop                     w_uop;
    logic signed [MUL_W-1:0]  w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_term, w_acc_abs;
    logic                     w_out_free, w_d2_ok, w_e2_ok, w_c_ok;

    assign w_in_p1 = '{x: i_data[23:0],   y: i_data[47:24]};
    assign w_in_p2 = '{x: i_data[71:48],  y: i_data[95:72]};
    assign w_in_p3 = '{x: i_data[119:96], y: i_data[143:120]};

    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_pt       = i_cmd.pt_sel ? r_seg.p2 : r_seg.p1;
    assign w_line_end = (r_op == OP_LINE) ? r_in_p1 : r_sub;
    assign w_half     = T_W'(T_HALF >> r_depth);

    // De Casteljau split at the parameter midpoint, each axis separately.
    always_comb begin
        t_coord m01, m12, m23, m012, m123, mid;
        t_coord n01, n12, n23, n012, n123, nid;
        m01  = half_floor(r_seg.p0.x, r_seg.p1.x);
        m12  = half_floor(r_seg.p1.x, r_seg.p2.x);
        m23  = half_floor(r_seg.p2.x, r_seg.p3.x);
        m012 = half_floor(m01, m12);
        m123 = half_floor(m12, m23);
        mid  = half_floor(m012, m123);
        n01  = half_floor(r_seg.p0.y, r_seg.p1.y);
        n12  = half_floor(r_seg.p1.y, r_seg.p2.y);
        n23  = half_floor(r_seg.p2.y, r_seg.p3.y);
        n012 = half_floor(n01, n12);
        n123 = half_floor(n12, n23);
        nid  = half_floor(n012, n123);
        w_left.p0  = r_seg.p0;
        w_left.p1  = '{x: m01,  y: n01};
        w_left.p2  = '{x: m012, y: n012};
        w_left.p3  = '{x: mid,  y: nid};
        w_left.t0  = r_seg.t0;
        w_right.p0 = '{x: mid,  y: nid};
        w_right.p1 = '{x: m123, y: n123};
        w_right.p2 = '{x: m23,  y: n23};
        w_right.p3 = r_seg.p3;
        w_right.t0 = r_seg.t0 + w_half;
    end

    assign w_uop = uop_of(i_cmd.step);

    function automatic logic signed [MUL_W-1:0] pick(
        input t_opnd sel, input logic [TOL_W-1:0] tol,
        input logic signed [DIFF_W-1:0] lx, ly, dx, dy, ex, ey,
        input logic [SQ_W-1:0] cabs, tol2, len2);
        logic signed [MUL_W-1:0] v;
        case (sel)
            OPD_TOL: v = {{(MUL_W-TOL_W){1'b0}}, tol};
            OPD_LX:  v = MUL_W'(lx);
            OPD_LY:  v = MUL_W'(ly);
            OPD_DX:  v = MUL_W'(dx);
            OPD_DY:  v = MUL_W'(dy);
            OPD_EX:  v = MUL_W'(ex);
            OPD_EY:  v = MUL_W'(ey);
            OPD_CLO: v = {1'b0, cabs[HALF_W-1:0]};
            OPD_CHI: v = {1'b0, cabs[SQ_W-1:HALF_W]};
            OPD_TLO: v = {1'b0, tol2[HALF_W-1:0]};
            OPD_THI: v = {1'b0, tol2[SQ_W-1:HALF_W]};
            OPD_NLO: v = {1'b0, len2[HALF_W-1:0]};
            OPD_NHI: v = {1'b0, len2[SQ_W-1:HALF_W]};
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_opa  = pick(w_uop.a, r_tol, r_lx, r_ly, r_dx, r_dy, r_ex, r_ey,
                         r_cabs, r_tol2, r_len2);
    assign w_opb  = pick(w_uop.b, r_tol, r_lx, r_ly, r_dx, r_dy, r_ex, r_ey,
                         r_cabs, r_tol2, r_len2);
    assign w_prod = w_opa * w_opb;

    always_comb begin
        w_term = ACC_W'(r_prod);
        case (r_pend_sh)
            SH_26:   w_term = w_term <<< HALF_W;
            SH_52:   w_term = w_term <<< (2 * HALF_W);
            default: ;
        endcase
    end

    assign w_acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // Distance of a control point from the chord segment, all in squared units.
    assign w_d2_ok = r_d2 <= r_tol2;
    assign w_e2_ok = r_e2 <= r_tol2;
    assign w_c_ok  = r_c2 <= r_rhs;

    always_comb begin
        o_sts.out_free    = w_out_free;
        o_sts.at_max      = r_depth == DEPTH_W'(MAX_DEPTH);
        o_sts.stack_empty = r_sp == '0;
        if (r_len2 == '0 || r_dot[SQ_W-1] || r_dot == '0) begin
            o_sts.near = w_d2_ok;
        end else if (r_dot >= $signed(r_len2)) begin
            o_sts.near = w_e2_ok;
        end else begin
            o_sts.near = w_c_ok;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= TOL_RESET;
            r_cur      <= '0;
            r_sub      <= '0;
            r_cnt      <= '0;
            r_sp       <= '0;
            r_depth    <= '0;
            r_o_valid  <= 1'b0;
            r_pend_acc <= ACC_NONE;
        end else begin
            if (i_cfg_wen) begin
                r_tol <= i_cfg_wdata;
            end
            r_pend_acc <= i_cmd.step_en ? w_uop.acc : ACC_NONE;
            if (i_cmd.accept) begin
                if (t_op'(i_op) == OP_MOVE) begin
                    r_cur <= w_in_p1;
                    r_sub <= w_in_p1;
                    r_cnt <= r_cnt + 1'b1;
                end
                r_sp    <= '0;
                r_depth <= '0;
            end
            if (i_cmd.emit_line) begin
                r_cur <= w_line_end;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.split) begin
                r_sp    <= r_sp + 1'b1;
                r_depth <= r_depth + 1'b1;
            end
            if (i_cmd.emit_leaf) begin
                if (r_sp == '0) begin
                    r_cur <= r_seg.p3;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_sp    <= r_sp - 1'b1;
                    r_depth <= r_stk_dep[SIDX_W'(r_sp - 1'b1)];
                end
            end
            if (i_cmd.emit_line || i_cmd.emit_leaf) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: command operands, segment, stack and arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_op);
            r_in_p1 <= w_in_p1;
            r_seg   <= '{p3: w_in_p3, p2: w_in_p2, p1: w_in_p1, p0: r_cur, t0: '0};
        end
        if (i_cmd.split) begin
            r_stk_seg[SIDX_W'(r_sp)] <= w_right;
            r_stk_dep[SIDX_W'(r_sp)] <= r_depth + 1'b1;
            r_seg                    <= w_left;
        end
        if (i_cmd.emit_leaf && r_sp != '0) begin
            r_seg <= r_stk_seg[SIDX_W'(r_sp - 1'b1)];
        end
        if (i_cmd.setup) begin
            r_lx <= DIFF_W'(r_seg.p3.x) - DIFF_W'(r_seg.p0.x);
            r_ly <= DIFF_W'(r_seg.p3.y) - DIFF_W'(r_seg.p0.y);
            r_dx <= DIFF_W'(w_pt.x) - DIFF_W'(r_seg.p0.x);
            r_dy <= DIFF_W'(w_pt.y) - DIFF_W'(r_seg.p0.y);
            r_ex <= DIFF_W'(w_pt.x) - DIFF_W'(r_seg.p3.x);
            r_ey <= DIFF_W'(w_pt.y) - DIFF_W'(r_seg.p3.y);
        end
        r_prod    <= w_prod;
        r_pend_sh <= w_uop.sh;
        case (r_pend_acc)
            ACC_LOAD: r_acc <= w_term;
            ACC_ADD:  r_acc <= r_acc + w_term;
            ACC_SUB:  r_acc <= r_acc - w_term;
            default:  ;
        endcase
        if (i_cmd.step_en) begin
            case (w_uop.st)
                ST_TOL2:  r_tol2 <= r_acc[SQ_W-1:0];
                ST_LEN2:  r_len2 <= r_acc[SQ_W-1:0];
                ST_DOT:   r_dot  <= r_acc[SQ_W-1:0];
                ST_D2:    r_d2   <= r_acc[SQ_W-1:0];
                ST_E2:    r_e2   <= r_acc[SQ_W-1:0];
                ST_CROSS: r_cabs <= w_acc_abs[SQ_W-1:0];
                ST_C2:    r_c2   <= r_acc;
                ST_RHS:   r_rhs  <= r_acc;
                default:  ;
            endcase
        end
        if (i_cmd.emit_line) begin
            r_o_kind <= (r_op == OP_LINE) ? KIND_LINE : KIND_CLOSE;
            r_o_last <= 1'b1;
            r_o_data <= {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, {(4*COORD_W){1'b0}},
                         w_line_end.y, w_line_end.x, r_cur.y, r_cur.x,
                         {T_W{1'b0}}, r_cnt};
        end
        if (i_cmd.emit_leaf) begin
            r_o_kind <= KIND_CUBIC;
            r_o_last <= r_sp == '0;
            r_o_data <= {{(OUT_DATA_W-OUT_FIELD_W){1'b0}},
                         r_seg.p2.y, r_seg.p2.x, r_seg.p1.y, r_seg.p1.x,
                         r_seg.p3.y, r_seg.p3.x, r_seg.p0.y, r_seg.p0.x,
                         r_seg.t0, r_cnt};
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_kind  = r_o_kind;
    assign o_out_last  = r_o_last;

endmodule

### test/cubic_bezier_path_flattener_top_tb.sv
// Self-checking testbench for the cubic Bezier path flattener: path commands in, predicted spans compared.
`timescale 1ns / 1ps

module cubic_bezier_path_flattener_top_tb;
    import cbpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    // One path command as it travels on the input stream.
    typedef struct {
        t_op    op;
        t_coord x1, y1, x2, y2, x3, y3;
    } path_cmd_t;

    // One span as it leaves the block.
    typedef struct {
        t_kind            kind;
        logic [15:0]      num;
        logic [T_W-1:0]   t0;
        logic             last;
        t_coord           sx, sy, ex, ey, c1x, c1y, c2x, c2y;
    } span_t;

    // A curve piece waiting on the halving stack.
    typedef struct {
        longint x[4];
        longint y[4];
        int     t0;
        int     depth;
    } piece_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [TOL_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  s_axis_tready_q;

    cubic_bezier_path_flattener_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Commands waiting for the driver, and spans the predictor says must come out.
    path_cmd_t pending_cmds[$];
    span_t     expected_spans[$];

    // Predictor state: a private copy of what the block keeps.
    longint    pen_x, pen_y, sub_x, sub_y;
    int        cmd_count;
    longint    tolerance;

    int        failures;
    int        idle_cycles;
    int        hold_off_cycles;   // receiver hold-off requested by the stimulus
    int        send_gap, recv_gap;

    // Appends a command to the driver's queue.
    task automatic queue_cmd(input path_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Appends a span to the list of expected spans.
    task automatic expect_span(input span_t s);
        expected_spans = {expected_spans, s};
    endtask

    // Draws a gap length: mostly none or short, now and then long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic longint sx24(input logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    // Midpoint rounded towards minus infinity.
    function automatic longint mid_floor(input longint a, input longint b);
        return (a + b) >>> 1;
    endfunction

    // Is point p within tolerance of segment a-b? Exact, using 128-bit products.
    function automatic bit within_tol(input longint px, input longint py,
                                      input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint lx, ly, dx, dy, len2, tol2, dotp, cr;
        logic [127:0] lhs, rhs;
        lx = bx - ax;
        ly = by - ay;
        dx = px - ax;
        dy = py - ay;
        tol2 = tolerance * tolerance;
        len2 = lx * lx + ly * ly;
        if (len2 == 0) begin
            return (dx * dx + dy * dy) <= tol2;
        end
        dotp = dx * lx + dy * ly;
        if (dotp <= 0) begin
            return (dx * dx + dy * dy) <= tol2;
        end
        if (dotp >= len2) begin
            return ((px - bx) * (px - bx) + (py - by) * (py - by)) <= tol2;
        end
        cr = dx * ly - dy * lx;
        if (cr < 0) begin
            cr = -cr;
        end
        lhs = 128'(cr) * 128'(cr);
        rhs = 128'(tol2) * 128'(len2);
        return lhs <= rhs;
    endfunction

    function automatic span_t make_span(input t_kind k, input int t0,
                                        input longint p[8]);
        span_t s;
        s.kind = k;
        s.num  = cmd_count[15:0];
        s.t0   = t0[T_W-1:0];
        s.last = 1'b0;
        s.sx   = p[0][23:0];
        s.sy   = p[1][23:0];
        s.ex   = p[2][23:0];
        s.ey   = p[3][23:0];
        s.c1x  = p[4][23:0];
        s.c1y  = p[5][23:0];
        s.c2x  = p[6][23:0];
        s.c2y  = p[7][23:0];
        return s;
    endfunction

    // Works out the spans of one accepted command and advances the pen.
    task automatic flatten_command(input path_cmd_t c);
        longint p[8];
        piece_t stack[$];
        piece_t s, a, b;
        span_t  sp;
        longint m01, m12, m23, m012, m123, mid;
        int     n, k, half;
        bit     flat;
        n = 0;
        case (c.op)
            OP_MOVE: begin
                pen_x = sx24(c.x1);
                pen_y = sx24(c.y1);
                sub_x = pen_x;
                sub_y = pen_y;
            end
            OP_LINE, OP_CLOSE: begin
                p = '{default: 0};
                p[0] = pen_x;
                p[1] = pen_y;
                p[2] = (c.op == OP_LINE) ? sx24(c.x1) : sub_x;
                p[3] = (c.op == OP_LINE) ? sx24(c.y1) : sub_y;
                sp = make_span((c.op == OP_LINE) ? KIND_LINE : KIND_CLOSE, 0, p);
                sp.last = 1'b1;
                expect_span(sp);
                pen_x = p[2];
                pen_y = p[3];
            end
            default: begin
                s.x[0] = pen_x;        s.y[0] = pen_y;
                s.x[1] = sx24(c.x1);   s.y[1] = sx24(c.y1);
                s.x[2] = sx24(c.x2);   s.y[2] = sx24(c.y2);
                s.x[3] = sx24(c.x3);   s.y[3] = sx24(c.y3);
                s.t0 = 0;
                s.depth = 0;
                stack = {stack, s};
                while (stack.size() > 0 && n < 64) begin
                    s = stack.pop_back();
                    flat = s.depth >= 6 ||
                        (within_tol(s.x[1], s.y[1], s.x[0], s.y[0], s.x[3], s.y[3]) &&
                         within_tol(s.x[2], s.y[2], s.x[0], s.y[0], s.x[3], s.y[3]));
                    if (flat) begin
                        p = '{s.x[0], s.y[0], s.x[3], s.y[3], s.x[1], s.y[1],
                              s.x[2], s.y[2]};
                        expect_span(make_span(KIND_CUBIC, s.t0, p));
                        n++;
                    end else begin
                        half = 64 >> (s.depth + 1);
                        for (k = 0; k < 2; k++) begin
                            longint q[4];
                            if (k == 0) begin
                                q = s.x;
                            end else begin
                                q = s.y;
                            end
                            m01  = mid_floor(q[0], q[1]);
                            m12  = mid_floor(q[1], q[2]);
                            m23  = mid_floor(q[2], q[3]);
                            m012 = mid_floor(m01, m12);
                            m123 = mid_floor(m12, m23);
                            mid  = mid_floor(m012, m123);
                            if (k == 0) begin
                                a.x = '{q[0], m01, m012, mid};
                                b.x = '{mid, m123, m23, q[3]};
                            end else begin
                                a.y = '{q[0], m01, m012, mid};
                                b.y = '{mid, m123, m23, q[3]};
                            end
                        end
                        a.t0 = s.t0;
                        b.t0 = s.t0 + half;
                        a.depth = s.depth + 1;
                        b.depth = s.depth + 1;
                        stack = {stack, b};
                        stack = {stack, a};
                    end
                end
                sp = expected_spans.pop_back();
                sp.last = 1'b1;
                expect_span(sp);
                pen_x = sx24(c.x3);
                pen_y = sx24(c.y3);
            end
        endcase
        cmd_count = (cmd_count + 1) & 16'hFFFF;
    endtask

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return (($urandom_range(0, 1) == 0) ? 24'h7FFFFF : 24'h800000);
        end else if (r < 4) begin
            return t_coord'($urandom);
        end
        // Modest coordinates keep curves shallow enough to flatten early.
        return t_coord'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic path_cmd_t rand_cmd(input t_op op);
        path_cmd_t c;
        c.op = op;
        c.x1 = rand_coord();
        c.y1 = rand_coord();
        c.x2 = rand_coord();
        c.y2 = rand_coord();
        c.x3 = rand_coord();
        c.y3 = rand_coord();
        return c;
    endfunction

    function automatic path_cmd_t mk_cmd(input t_op op, input int x1, input int y1,
                                         input int x2, input int y2,
                                         input int x3, input int y3);
        path_cmd_t c;
        c.op = op;
        c.x1 = x1[23:0];
        c.y1 = y1[23:0];
        c.x2 = x2[23:0];
        c.y2 = y2[23:0];
        c.x3 = x3[23:0];
        c.y3 = y3[23:0];
        return c;
    endfunction

    // Writes the tolerance register; only called while the block is idle.
    task automatic write_tolerance(input int unsigned value);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value[TOL_W-1:0];
        tolerance    = value;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Waits until every command has been taken and every span checked.
    task automatic drain();
        while (pending_cmds.size() > 0 || expected_spans.size() > 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        // A move produces no span but may still be in flight; let it settle.
        repeat (20) @(posedge i_clk);
    endtask

    // Driver: offers queued commands, with random gaps, on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready_q) begin
            // Beat still on offer; hold it.
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            path_cmd_t c;
            c = pending_cmds.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {c.y3, c.x3, c.y2, c.x2, c.y1, c.x1};
            s_axis_tuser  <= c.op;
            send_gap       = draw_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Handshake on the input side, recorded at the rising edge; the accepted
    // command is predicted at that moment.
    always @(posedge i_clk) begin
        s_axis_tready_q <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            path_cmd_t c;
            c.op = t_op'(s_axis_tuser);
            {c.y3, c.x3, c.y2, c.x2, c.y1, c.x1} = s_axis_tdata;
            flatten_command(c);
        end
    end

    // Receiver back-pressure, including the requested long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                recv_gap = draw_gap();
            end
        end
    end

    // Monitor: compares every accepted span with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            span_t e;
            span_t g;
            g.kind = t_kind'(m_axis_tuser);
            g.last = m_axis_tlast;
            {g.c2y, g.c2x, g.c1y, g.c1x, g.ey, g.ex, g.sy, g.sx, g.t0, g.num} =
                m_axis_tdata[OUT_FIELD_W-1:0];
            if (expected_spans.size() == 0) begin
                $error("span arrived with none expected");
                failures++;
            end else begin
                e = expected_spans.pop_front();
                if (g.kind != e.kind) begin
                    $error("span_kind: expected %0d, got %0d", e.kind, g.kind);
                    failures++;
                end
                if (g.num != e.num) begin
                    $error("command_number: expected %0d, got %0d", e.num, g.num);
                    failures++;
                end
                if (g.t0 != e.t0) begin
                    $error("t_start: expected %0d, got %0d", e.t0, g.t0);
                    failures++;
                end
                if (g.last != e.last) begin
                    $error("last_of_run: expected %0d, got %0d", e.last, g.last);
                    failures++;
                end
                if (g.sx != e.sx) begin
                    $error("start_x: expected %0d, got %0d", e.sx, g.sx);
                    failures++;
                end
                if (g.sy != e.sy) begin
                    $error("start_y: expected %0d, got %0d", e.sy, g.sy);
                    failures++;
                end
                if (g.ex != e.ex) begin
                    $error("end_x: expected %0d, got %0d", e.ex, g.ex);
                    failures++;
                end
                if (g.ey != e.ey) begin
                    $error("end_y: expected %0d, got %0d", e.ey, g.ey);
                    failures++;
                end
                if (g.c1x != e.c1x) begin
                    $error("ctrl1_x: expected %0d, got %0d", e.c1x, g.c1x);
                    failures++;
                end
                if (g.c1y != e.c1y) begin
                    $error("ctrl1_y: expected %0d, got %0d", e.c1y, g.c1y);
                    failures++;
                end
                if (g.c2x != e.c2x) begin
                    $error("ctrl2_x: expected %0d, got %0d", e.c2x, g.c2x);
                    failures++;
                end
                if (g.c2y != e.c2y) begin
                    $error("ctrl2_y: expected %0d, got %0d", e.c2y, g.c2y);
                    failures++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Builds a path of random commands: mostly curves and lines, with some moves and closes.
    task automatic queue_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                queue_cmd(rand_cmd(OP_MOVE));
            end else if (r < 5) begin
                queue_cmd(rand_cmd(OP_LINE));
            end else if (r < 9) begin
                queue_cmd(rand_cmd(OP_CURVE));
            end else begin
                queue_cmd(rand_cmd(OP_CLOSE));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_MOVE;
        m_axis_tready   = 1'b0;
        pen_x = 0; pen_y = 0; sub_x = 0; sub_y = 0;
        cmd_count       = 0;
        tolerance       = 64;
        failures        = 0;
        idle_cycles     = 0;
        hold_off_cycles = 0;
        send_gap        = 0;
        recv_gap        = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset tolerance: commands before any move use the
        // origin, then every kind of command and the coordinate extremes.
        queue_cmd(mk_cmd(OP_LINE, 256, 512, 0, 0, 0, 0));
        queue_cmd(mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(OP_CURVE, 100, 300, 200, -300, 400, 0));
        queue_cmd(mk_cmd(OP_MOVE, 8388607, -8388608, 5, 5, 5, 5));
        queue_cmd(mk_cmd(OP_LINE, -8388608, 8388607, -1, -1, -1, -1));
        queue_cmd(mk_cmd(OP_CURVE, 8388607, 8388607, -8388608, -8388608,
                         8388607, -8388608));
        queue_cmd(mk_cmd(OP_CLOSE, -1, -1, -1, -1, -1, -1));
        // Degenerate chord: start and end coincide.
        queue_cmd(mk_cmd(OP_MOVE, 1000, 1000, 0, 0, 0, 0));
        queue_cmd(mk_cmd(OP_CURVE, 1020, 1010, 990, 1000, 1000, 1000));
        // A curve already flat, and one with control points beyond the ends.
        queue_cmd(mk_cmd(OP_CURVE, 1100, 1000, 1200, 1000, 1300, 1000));
        queue_cmd(mk_cmd(OP_CURVE, 900, 1000, 1500, 1000, 1400, 1000));
        queue_cmd(mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0));
        drain();

        // Zero is outside the range, so the smallest tolerance is one.
        write_tolerance(1);
        queue_cmd(mk_cmd(OP_CURVE, 1000, 1000, 1000, 1000, 1000, 1000));
        queue_cmd(mk_cmd(OP_CURVE, 2000, 4000, 6000, -4000, 8000, 0));
        queue_cmd(mk_cmd(OP_LINE, 0, 0, 0, 0, 0, 0));
        queue_random(40);
        drain();

        // Largest tolerance: almost every curve is flat at once.
        write_tolerance(23'h7FFFFF);
        queue_random(60);
        drain();

        // Long receiver hold-off while the sender keeps offering commands.
        write_tolerance(256);
        hold_off_cycles = 3000;
        queue_random(30);
        drain();

        write_tolerance($urandom_range(1, 23'h7FFFFF));
        queue_random(80);
        drain();

        write_tolerance($urandom_range(16, 4096));
        queue_random(100);
        drain();

        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
